@@ src/ssid_pkg.sv @@
// Package for the sorted set insert/delete unit.
// Holds the operation and status codes and the structs passed between the top level
// and the compare-and-shift cells. It depends on nothing else.
`default_nettype none

package ssid_pkg;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_DELETED   = 3'd2;
   localparam logic [2:0] ST_NOT_FOUND = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   localparam int KeyW = 32;

   typedef struct packed {
      logic do_insert;
      logic do_delete;
   } cell_ctrl_type;

   typedef struct packed {
      logic lt;
      logic eq;
   } cell_flags_type;

endpackage

`default_nettype wire

@@ src/ssid_cell.sv @@
// One compare-and-shift cell of the sorted set unit: holds one key.
// It compares its key with the pending key and takes its neighbor's key on a shift.
// It depends on ssid_pkg.
`default_nettype none

module ssid_cell (
   input  wire logic                          clock,
   input  wire logic                          occupied,
   input  wire logic signed [31:0]            item_key,
   input  wire ssid_pkg::cell_ctrl_type       ctrl,
   input  wire logic                          prev_lt,
   input  wire logic signed [31:0]            prev_key,
   input  wire logic signed [31:0]            next_key,
   output      ssid_pkg::cell_flags_type      flags,
   output      logic signed [31:0]            key
);
   import ssid_pkg::*;

   logic signed [KeyW-1:0] key_ff;
   logic signed [KeyW-1:0] key_in;

   always_comb begin
      flags.lt = occupied && (key_ff < item_key);
      flags.eq = occupied && (key_ff == item_key);
   end

   always_comb begin
      key_in = key_ff;
      if (ctrl.do_insert && !flags.lt) begin
         key_in = prev_lt ? item_key : prev_key;
      end else if (ctrl.do_delete && !flags.lt) begin
         key_in = next_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key = key_ff;

endmodule

`default_nettype wire

@@ src/sorted_set_insert_delete_unit.sv @@
// Sorted set insert/delete unit: a row of CAPACITY compare-and-shift cells keeps the keys in order.
// A request waits in the item registers and is applied, its result going to the result register,
// once the result register is free. Throughput, while rsp_ready holds: one operation per cycle;
// every cell compares and shifts in the same cycle.
// Reset (synchronous, active high) empties the set and clears both channel valids.
// Depends on ssid_pkg and ssid_cell.
`default_nettype none

module sorted_set_insert_delete_unit #(
   parameter int CAPACITY = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output      logic               req_ready,
   input  wire logic               req_opcode,
   input  wire logic signed [31:0] req_value,
   output      logic               rsp_valid,
   input  wire logic               rsp_ready,
   output      logic [2:0]         rsp_status,
   output      logic [3:0]         rsp_position,
   output      logic [4:0]         rsp_count
);
   import ssid_pkg::*;

   localparam int PosW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CntW = $clog2(CAPACITY + 1);

   logic                   item_valid_ff;
   logic                   item_valid_in;
   logic                   item_op_ff;
   logic signed [KeyW-1:0] item_key_ff;
   logic [CntW-1:0]        count_ff;
   logic [CntW-1:0]        count_in;

   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [2:0]             rsp_status_ff;
   logic [2:0]             rsp_status_in;
   logic [3:0]             rsp_position_ff;
   logic [3:0]             rsp_position_in;
   logic [4:0]             rsp_count_ff;
   logic [4:0]             rsp_count_in;

   logic                   apply_fire;
   logic                   req_fire;
   logic                   present;
   logic                   full;
   logic [PosW-1:0]        pos_idx;
   logic [31:0]            pos_ext;
   logic [31:0]            cnt_ext;
   cell_ctrl_type          ctrl;

   cell_flags_type         flags [CAPACITY];
   logic signed [KeyW-1:0] keys [CAPACITY];
   logic [CAPACITY-1:0]    lt_vec;
   logic [CAPACITY-1:0]    eq_vec;
   logic [CAPACITY-1:0]    boundary;

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic                   occupied;
         logic                   prev_lt;
         logic signed [KeyW-1:0] prev_key;
         logic signed [KeyW-1:0] next_key;

         assign occupied = count_ff > CntW'(g);
         if (g == 0) begin : g_first
            assign prev_lt  = 1'b1;
            assign prev_key = item_key_ff;
         end else begin : g_inner
            assign prev_lt  = lt_vec[g-1];
            assign prev_key = keys[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign next_key = keys[g];
         end else begin : g_mid
            assign next_key = keys[g+1];
         end

         ssid_cell u_cell (
            .clock    (clock),
            .occupied (occupied),
            .item_key (item_key_ff),
            .ctrl     (ctrl),
            .prev_lt  (prev_lt),
            .prev_key (prev_key),
            .next_key (next_key),
            .flags    (flags[g]),
            .key      (keys[g])
         );

         assign lt_vec[g]   = flags[g].lt;
         assign eq_vec[g]   = flags[g].eq;
         assign boundary[g] = !flags[g].lt && prev_lt;
      end
   endgenerate

   assign apply_fire = item_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !item_valid_ff || apply_fire;
   assign req_fire   = req_valid && req_ready;
   assign present    = |eq_vec;
   assign full       = count_ff == CntW'(CAPACITY);

   always_comb begin
      pos_idx = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (boundary[i]) begin
            pos_idx = pos_idx | PosW'(i);
         end
      end
   end

   always_comb begin
      ctrl.do_insert = apply_fire && (item_op_ff == OP_INSERT) && !present && !full;
      ctrl.do_delete = apply_fire && (item_op_ff == OP_DELETE) && present;
   end

   always_comb begin
      count_in      = count_ff;
      rsp_status_in = ST_NOT_FOUND;
      pos_ext       = '0;
      priority if (item_op_ff == OP_INSERT && present) begin
         rsp_status_in = ST_DUPLICATE;
      end else if (item_op_ff == OP_INSERT && full) begin
         rsp_status_in = ST_FULL;
      end else if (item_op_ff == OP_INSERT) begin
         rsp_status_in = ST_INSERTED;
         pos_ext       = 32'(pos_idx);
         count_in      = count_ff + CntW'(1);
      end else if (present) begin
         rsp_status_in = ST_DELETED;
         pos_ext       = 32'(pos_idx);
         count_in      = count_ff - CntW'(1);
      end else begin
         rsp_status_in = ST_NOT_FOUND;
      end
      cnt_ext         = 32'(count_in);
      rsp_position_in = pos_ext[3:0];
      rsp_count_in    = cnt_ext[4:0];
   end

   always_comb begin
      item_valid_in = item_valid_ff;
      if (req_fire) begin
         item_valid_in = 1'b1;
      end else if (apply_fire) begin
         item_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (apply_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         count_ff      <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (apply_fire) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_op_ff  <= req_opcode;
         item_key_ff <= req_value;
      end
      if (apply_fire) begin
         rsp_status_ff   <= rsp_status_in;
         rsp_position_ff <= rsp_position_in;
         rsp_count_ff    <= rsp_count_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_count    = rsp_count_ff;

endmodule

`default_nettype wire

@@ src/ssid_checker.sv @@
// Port-level checks for the sorted set insert/delete unit, and the bind that attaches them.
// Depends on ssid_pkg and the top level's port list.
`default_nettype none

module ssid_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_status,
   input wire logic [3:0]  rsp_position,
   input wire logic [4:0]  rsp_count
);
   import ssid_pkg::*;

   // No result may be offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // A refused or missed operation changes nothing, so it reports position zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_DUPLICATE || rsp_status == ST_NOT_FOUND ||
                    rsp_status == ST_FULL) |-> rsp_position == 4'd0)
      else $error("position nonzero on an operation that changed nothing");

   // Only the five defined status codes appear.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_FULL)
      else $error("undefined status code");

   // A stalled result holds until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
                                  $stable(rsp_position) && $stable(rsp_count))
      else $error("stalled result changed");

endmodule

bind sorted_set_insert_delete_unit ssid_checker u_ssid_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_status   (rsp_status),
   .rsp_position (rsp_position),
   .rsp_count    (rsp_count)
);

`default_nettype wire
